[rtl/tps_pkg.sv]
package tps_pkg;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_TEXT   = 2'd2;
	localparam logic [1:0] ACT_END    = 2'd3;

	localparam logic [1:0] EV_MATCH    = 2'd0;
	localparam logic [1:0] EV_END      = 2'd1;
	localparam logic [1:0] EV_OVERFLOW = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MODE = 2'd1;

	localparam int POS_W = 32;

	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_value;
	} item_t;

	typedef struct packed {
		logic [1:0]       event_kind;
		logic [POS_W-1:0] position;
		logic             any_found;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic                 value;
	} cfg_t;

	typedef struct packed {
		logic       scan;
		logic       append;
		logic       fold_case;
		logic       reverse_mode;
		logic [7:0] text_fold;
		logic [7:0] char_value;
	} cell_ctrl_t;

	function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

[rtl/tps_stream_if.sv]
interface tps_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/tps_cell.sv]
module tps_cell #(
	parameter int IDX   = 0,
	parameter int LEN_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tps_pkg::cell_ctrl_t   ctrl,
	input  logic                  clear,
	input  logic [LEN_W-1:0]      len,
	input  logic                  prev_bit,
	input  logic [7:0]            prev_char,
	output logic                  match_bit,
	output logic [7:0]            rev_char,
	output logic                  hit
);

	logic [7:0] fwd_char_q;
	logic [7:0] rev_char_q;
	logic       bit_q;
	logic       active;
	logic       last;
	logic [7:0] cmp_char;
	logic       bit_next;

	assign active    = len > LEN_W'(IDX);
	assign last      = len == LEN_W'(IDX + 1);
	assign cmp_char  = ctrl.reverse_mode ? rev_char_q : fwd_char_q;
	assign bit_next  = prev_bit && active &&
		(tps_pkg::fold_char(cmp_char, ctrl.fold_case) == ctrl.text_fold);
	assign hit       = ctrl.scan && last && bit_next;
	assign match_bit = bit_q;
	assign rev_char  = rev_char_q;

	always_ff @(posedge clk) begin
		if (ctrl.append) begin
			rev_char_q <= prev_char;
			if (len == LEN_W'(IDX)) begin
				fwd_char_q <= ctrl.char_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (clear) begin
			bit_q <= 1'b0;
		end else if (ctrl.scan) begin
			bit_q <= bit_next;
		end
	end

endmodule

[rtl/text_pattern_search_core.sv]
// Exact string search, case-insensitive while fold case is set. Load a pattern with clear and append beats, then
// stream text one character per beat and close the stream with an end beat. Each cell of
// the row holds one pattern character in forward order, one in reverse order and one
// partial-match bit; all cells update in the same cycle, so a beat of any action is taken
// without waiting on the row. A match, end or overflow event appears on the result channel in the
// cycle after its beat. While an event waits there unaccepted, the input is held off; the
// next beat is taken in the same cycle that the event is accepted, so beats run back to back
// as long as the result channel is ready. The critical path is one character compare per
// cell, the OR of the row's match taps and the clear fanout back to every cell.
module text_pattern_search_core #(
	parameter int MAX_PATTERN = 128
) (
	input logic          clk,
	input logic          arst_n,
	tps_stream_if.sink   item,
	tps_stream_if.source result,
	tps_stream_if.sink   cfg
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [LEN_W-1:0]         len_q;
	logic [tps_pkg::POS_W-1:0] pos_q;
	logic [tps_pkg::POS_W-1:0] pos_inc;
	logic                     found_q;
	logic                     fold_q;
	logic                     reverse_q;
	logic                     res_valid_q;
	tps_pkg::result_t         res_q;
	tps_pkg::result_t         res_d;
	logic                     res_set;
	logic                     accept;
	logic                     full;
	logic                     hit;
	logic                     clear_all;
	logic [1:0]               act;
	tps_pkg::cell_ctrl_t      ctrl;

	logic [MAX_PATTERN-1:0]   bits;
	logic [MAX_PATTERN-1:0]   hits;
	logic [7:0]               revs [MAX_PATTERN];

	assign item.ready   = !res_valid_q || result.ready;
	assign cfg.ready    = 1'b1;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	assign accept  = item.valid && item.ready;
	assign act     = item.data.action;
	assign full    = len_q == LEN_W'(MAX_PATTERN);
	assign pos_inc = pos_q + tps_pkg::POS_W'(1);
	assign hit     = |hits;

	assign ctrl.scan         = accept && act == tps_pkg::ACT_TEXT;
	assign ctrl.append       = accept && act == tps_pkg::ACT_APPEND && !full;
	assign ctrl.fold_case    = fold_q;
	assign ctrl.reverse_mode = reverse_q;
	assign ctrl.text_fold    = tps_pkg::fold_char(item.data.char_value, fold_q);
	assign ctrl.char_value   = item.data.char_value;

	assign clear_all = accept && (act == tps_pkg::ACT_CLEAR || act == tps_pkg::ACT_END ||
		(act == tps_pkg::ACT_APPEND && !full) || (act == tps_pkg::ACT_TEXT && hit));

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic       prev_bit;
		logic [7:0] prev_char;

		if (i == 0) begin : g_head
			assign prev_bit  = 1'b1;
			assign prev_char = item.data.char_value;
		end else begin : g_body
			assign prev_bit  = bits[i-1];
			assign prev_char = revs[i-1];
		end

		tps_cell #(
			.IDX   (i),
			.LEN_W (LEN_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.clear     (clear_all),
			.len       (len_q),
			.prev_bit  (prev_bit),
			.prev_char (prev_char),
			.match_bit (bits[i]),
			.rev_char  (revs[i]),
			.hit       (hits[i])
		);
	end

	always_comb begin
		res_set = 1'b0;
		res_d.event_kind = tps_pkg::EV_MATCH;
		res_d.position   = pos_q;
		res_d.any_found  = 1'b0;
		if (accept) begin
			unique case (act)
				tps_pkg::ACT_CLEAR: begin
				end
				tps_pkg::ACT_APPEND: begin
					if (full) begin
						res_set = 1'b1;
						res_d.event_kind = tps_pkg::EV_OVERFLOW;
					end
				end
				tps_pkg::ACT_TEXT: begin
					if (hit) begin
						res_set = 1'b1;
						res_d.position = pos_inc;
					end
				end
				tps_pkg::ACT_END: begin
					res_set = 1'b1;
					res_d.event_kind = tps_pkg::EV_END;
					res_d.any_found  = found_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			fold_q      <= 1'b0;
			reverse_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.data.index)
					tps_pkg::REG_FOLD_CASE:    fold_q    <= cfg.data.value;
					tps_pkg::REG_REVERSE_MODE: reverse_q <= cfg.data.value;
					default: begin
					end
				endcase
			end
			if (accept) begin
				unique case (act)
					tps_pkg::ACT_CLEAR: len_q <= '0;
					tps_pkg::ACT_APPEND: begin
						if (!full) begin
							len_q <= len_q + LEN_W'(1);
						end
					end
					tps_pkg::ACT_TEXT: begin
						pos_q <= pos_inc;
						if (hit) begin
							found_q <= 1'b1;
						end
					end
					tps_pkg::ACT_END: begin
						pos_q   <= '0;
						found_q <= 1'b0;
					end
				endcase
			end
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_set) begin
			res_q <= res_d;
		end
	end

endmodule

[rtl/tps_checker.sv]
module tps_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_ready,
	input logic [1:0]                item_action,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic [1:0]                result_event_kind,
	input logic [tps_pkg::POS_W-1:0] result_position,
	input logic                      result_any_found
);

	logic item_beat;

	assign item_beat = item_valid && item_ready;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_event_kind) && $stable(result_position))
		else $error("result beat changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty result register");

	a_end_reports: assert property (@(posedge clk) disable iff (!arst_n)
		item_beat && item_action == tps_pkg::ACT_END |=>
			result_valid && result_event_kind == tps_pkg::EV_END)
		else $error("end of text gave no end event");

	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_beat && item_action == tps_pkg::ACT_CLEAR && !result_valid |=> !result_valid)
		else $error("clear pattern produced a result");

	a_found_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_event_kind != tps_pkg::EV_END |-> !result_any_found)
		else $error("any_found set outside end event");

endmodule

bind text_pattern_search_core tps_checker u_tps_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_action       (item.data.action),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_event_kind (result.data.event_kind),
	.result_position   (result.data.position),
	.result_any_found  (result.data.any_found)
);

[sim/tb_text_pattern_search_core.sv]
module tb_text_pattern_search_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAT = 128;
	localparam int HOLD_LEN = 300;
	localparam int PHASE_ITEMS = 240;
	localparam logic [tps_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [tps_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	tps_stream_if #(.payload_t(tps_pkg::item_t)) item_if ();
	tps_stream_if #(.payload_t(tps_pkg::result_t)) result_if ();
	tps_stream_if #(.payload_t(tps_pkg::cfg_t)) cfg_if ();

	text_pattern_search_core #(.MAX_PATTERN(MAX_PAT)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	tps_pkg::item_t   pending_items [$];
	tps_pkg::cfg_t    pending_writes [$];
	tps_pkg::result_t expected_events [$];

	logic [7:0]       pat_store [MAX_PAT];
	int               pat_len;
	logic [MAX_PAT-1:0] match_vec;
	logic [tps_pkg::POS_W-1:0] text_pos;
	logic             found;
	logic             fold_on;
	logic             rev_on;

	int send_idle_pct;
	int recv_stall_pct;
	logic hold_req;
	int hold_count;
	int mismatches;
	int items_queued;
	logic phase_fold;
	logic phase_rev;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		if (fold_on && c >= tps_pkg::CHAR_LOWER_A && c <= tps_pkg::CHAR_LOWER_Z)
			return c - tps_pkg::CASE_OFFSET;
		return c;
	endfunction

	function automatic void search_step(input tps_pkg::item_t it);
		logic [MAX_PAT-1:0] shifted;
		logic [MAX_PAT-1:0] mask;
		logic [7:0] t;
		int idx;
		tps_pkg::result_t ev;
		ev = '0;
		case (it.action)
			tps_pkg::ACT_CLEAR: begin
				pat_len = 0;
				match_vec = '0;
			end
			tps_pkg::ACT_APPEND: begin
				if (pat_len >= MAX_PAT) begin
					ev.event_kind = tps_pkg::EV_OVERFLOW;
					ev.position = text_pos;
					expected_events.push_back(ev);
				end else begin
					pat_store[pat_len] = it.char_value;
					pat_len++;
					match_vec = '0;
				end
			end
			tps_pkg::ACT_TEXT: begin
				text_pos = text_pos + 1'b1;
				t = fold_upper(it.char_value);
				shifted = {match_vec[MAX_PAT-2:0], 1'b1};
				mask = '0;
				for (int k = 0; k < pat_len; k++) begin
					idx = rev_on ? pat_len - 1 - k : k;
					if (fold_upper(pat_store[idx]) == t)
						mask[k] = 1'b1;
				end
				match_vec = shifted & mask;
				if (pat_len != 0 && match_vec[pat_len-1]) begin
					match_vec = '0;
					found = 1'b1;
					ev.event_kind = tps_pkg::EV_MATCH;
					ev.position = text_pos;
					expected_events.push_back(ev);
				end
			end
			default: begin
				ev.event_kind = tps_pkg::EV_END;
				ev.position = text_pos;
				ev.any_found = found;
				expected_events.push_back(ev);
				text_pos = '0;
				found = 1'b0;
				match_vec = '0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
			item_if.data <= '0;
		end else begin
			if (item_if.valid && item_if.ready)
				search_step(item_if.data);
			if (!item_if.valid || item_if.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_if.valid <= 1'b1;
					item_if.data <= pending_items.pop_front();
				end else begin
					item_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_if.valid <= 1'b0;
			cfg_if.data <= '0;
		end else begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.data.index)
					tps_pkg::REG_FOLD_CASE: fold_on = cfg_if.data.value;
					tps_pkg::REG_REVERSE_MODE: rev_on = cfg_if.data.value;
					default: ;
				endcase
			end
			if (!cfg_if.valid || cfg_if.ready) begin
				if (pending_writes.size() != 0) begin
					cfg_if.valid <= 1'b1;
					cfg_if.data <= pending_writes.pop_front();
				end else begin
					cfg_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_count <= 0;
		else if (!hold_req)
			hold_count <= 0;
		else if (hold_count < HOLD_LEN)
			hold_count <= hold_count + 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_if.ready <= 1'b0;
		else
			result_if.ready <= !(hold_req && hold_count < HOLD_LEN) &&
				($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		tps_pkg::result_t want;
		tps_pkg::result_t got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = result_if.data;
			if (expected_events.size() == 0) begin
				$error("event with none pending: event_kind %0d position %0d any_found %0d",
					got.event_kind, got.position, got.any_found);
				mismatches++;
			end else begin
				want = expected_events.pop_front();
				if (got.event_kind !== want.event_kind) begin
					$error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
					mismatches++;
				end
				if (got.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, got.position);
					mismatches++;
				end
				if (got.any_found !== want.any_found) begin
					$error("any_found: expected %0d, got %0d", want.any_found, got.any_found);
					mismatches++;
				end
			end
		end
	end

	function automatic void push_item(input logic [1:0] act, input logic [7:0] ch);
		tps_pkg::item_t it;
		it.action = act;
		it.char_value = ch;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void push_write(input logic [tps_pkg::CFG_IDX_W-1:0] idx,
		input logic val);
		tps_pkg::cfg_t w;
		w.index = idx;
		w.value = val;
		pending_writes.push_back(w);
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(13))
			0: return 8'h61;
			1: return 8'h62;
			2: return 8'h41;
			3: return 8'h42;
			4: return 8'h0A;
			5: return 8'h40;
			6: return 8'h5B;
			7: return 8'h60;
			8: return 8'h7B;
			9: return 8'h7A;
			10: return 8'h5A;
			11: return 8'h61;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void push_copy(input logic [7:0] pat [$]);
		logic [7:0] c;
		int n;
		n = pat.size();
		for (int j = 0; j < n; j++) begin
			c = phase_rev ? pat[n-1-j] : pat[j];
			if (phase_fold && $urandom_range(1)) begin
				if (c >= tps_pkg::CHAR_LOWER_A && c <= tps_pkg::CHAR_LOWER_Z)
					c = c - tps_pkg::CASE_OFFSET;
				else if (c >= tps_pkg::CHAR_LOWER_A - tps_pkg::CASE_OFFSET &&
					c <= tps_pkg::CHAR_LOWER_Z - tps_pkg::CASE_OFFSET)
					c = c + tps_pkg::CASE_OFFSET;
			end
			push_item(tps_pkg::ACT_TEXT, c);
		end
	endfunction

	function automatic void gen_search(input int plen, input int tlen, input int overflows);
		logic [7:0] pat [$];
		logic [7:0] c;
		int n;
		push_item(tps_pkg::ACT_CLEAR, 8'($urandom_range(255)));
		for (int i = 0; i < plen; i++) begin
			c = pick_char();
			pat.push_back(c);
			push_item(tps_pkg::ACT_APPEND, c);
		end
		n = 0;
		while (n < tlen) begin
			if (plen > 0 && $urandom_range(3) == 0) begin
				push_copy(pat);
				n += plen;
			end else begin
				push_item(tps_pkg::ACT_TEXT, pick_char());
				n++;
			end
			if (overflows > 0 && $urandom_range(5) == 0) begin
				push_item(tps_pkg::ACT_APPEND, 8'($urandom_range(255)));
				overflows--;
			end
		end
		for (int i = 0; i < overflows; i++)
			push_item(tps_pkg::ACT_APPEND, 8'($urandom_range(255)));
		if (plen > 0)
			push_copy(pat);
		push_item(tps_pkg::ACT_END, 8'($urandom_range(255)));
	endfunction

	task automatic drain();
		while (pending_items.size() != 0 || item_if.valid || expected_events.size() != 0 ||
			pending_writes.size() != 0 || cfg_if.valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int target;
		int plen;
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		result_if.ready = 1'b0;
		pat_len = 0;
		match_vec = '0;
		text_pos = '0;
		found = 1'b0;
		fold_on = 1'b0;
		rev_on = 1'b0;
		for (int i = 0; i < MAX_PAT; i++)
			pat_store[i] = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		mismatches = 0;
		items_queued = 0;
		phase_fold = 1'b0;
		phase_rev = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_item(tps_pkg::ACT_END, 8'h00);
		push_item(tps_pkg::ACT_TEXT, 8'h00);
		push_item(tps_pkg::ACT_TEXT, 8'hFF);
		push_item(tps_pkg::ACT_APPEND, 8'hFF);
		push_item(tps_pkg::ACT_CLEAR, 8'h55);
		push_item(tps_pkg::ACT_APPEND, 8'h61);
		push_item(tps_pkg::ACT_APPEND, 8'h42);
		push_item(tps_pkg::ACT_TEXT, 8'h61);
		push_item(tps_pkg::ACT_TEXT, 8'h42);
		push_item(tps_pkg::ACT_TEXT, 8'h41);
		push_item(tps_pkg::ACT_TEXT, 8'h42);
		push_item(tps_pkg::ACT_TEXT, 8'h0A);
		push_item(tps_pkg::ACT_TEXT, 8'h61);
		push_item(tps_pkg::ACT_TEXT, 8'h61);
		push_item(tps_pkg::ACT_TEXT, 8'h42);
		push_item(tps_pkg::ACT_END, 8'hAA);
		push_item(tps_pkg::ACT_APPEND, 8'h61);
		push_item(tps_pkg::ACT_TEXT, 8'h61);
		push_item(tps_pkg::ACT_TEXT, 8'h42);
		push_item(tps_pkg::ACT_TEXT, 8'h61);
		push_item(tps_pkg::ACT_END, 8'hFF);
		drain();

		hold_req = 1'b1;
		push_item(tps_pkg::ACT_CLEAR, 8'h00);
		push_item(tps_pkg::ACT_APPEND, 8'h61);
		for (int i = 0; i < 40; i++)
			push_item(tps_pkg::ACT_TEXT, 8'h61);
		push_item(tps_pkg::ACT_END, 8'h00);
		while (hold_count < HOLD_LEN)
			@(negedge clk);
		hold_req = 1'b0;
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin phase_fold = 1'b1; phase_rev = 1'b0; end
				1: begin phase_fold = 1'b0; phase_rev = 1'b1; end
				2: begin phase_fold = 1'b1; phase_rev = 1'b1; end
				default: begin phase_fold = 1'b0; phase_rev = 1'b0; end
			endcase
			push_write(REG_SPARE_A, 1'($urandom_range(1)));
			push_write(tps_pkg::REG_FOLD_CASE, phase_fold);
			push_write(tps_pkg::REG_REVERSE_MODE, phase_rev);
			push_write(REG_SPARE_B, 1'($urandom_range(1)));
			drain();
			case (p)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 66; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 66; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			target = items_queued + PHASE_ITEMS;
			if (p == 2)
				gen_search(MAX_PAT, 20, 2);
			while (items_queued < target) begin
				case ($urandom_range(9))
					0: begin
						for (int i = $urandom_range(8); i >= 0; i--)
							push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
					end
					1: gen_search(0, $urandom_range(10, 2), 0);
					2: begin
						if ($urandom_range(9) == 0)
							gen_search($urandom_range(70, 60), 10, 0);
						else
							gen_search($urandom_range(6, 1), $urandom_range(30, 5), 0);
					end
					default: begin
						plen = $urandom_range(6, 1);
						gen_search(plen, $urandom_range(30, 5), 0);
					end
				endcase
			end
			drain();
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
